>>> rtl/core/mmp_pkg.sv
// ----------------------------------------------------------------------------
// mmp_pkg
// Shared types and constants for the moisture median/percent block.
// ----------------------------------------------------------------------------
package mmp_pkg;

  localparam int RAW_W     = 12;  // converter sample and calibration width
  localparam int PCT_W     = 7;   // percent output width
  localparam int CFG_IDX_W = 3;   // register index width (room for unused codes)
  localparam int PROD_W    = 19;  // |median - dry| * 100 fits here
  localparam int QBIT_W    = 3;   // quotient bit counter, bits 6..0

  localparam logic [PCT_W-1:0]  PCT_FULL  = 7'd100;
  localparam logic [PCT_W-1:0]  PCT_ZERO  = 7'd0;
  localparam logic [QBIT_W-1:0] QBIT_TOP  = 3'd6;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DRY_RAW    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WET_RAW    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VALID_HIGH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VALID_LOW  = 3'd3;

  // Reset values of the calibration registers
  localparam logic [RAW_W-1:0] RAW_MAX = 12'd4095;
  localparam logic [RAW_W-1:0] RAW_MIN = 12'd0;

  typedef enum logic [2:0] {
    S_IDLE,   // waiting for a request
    S_CAND,   // read candidate entry
    S_CWAIT,  // capture candidate, start scan
    S_SCAN,   // stream all entries past the candidate, count those ranked below it
    S_RANK,   // check candidate rank, set up the mapping
    S_DIV,    // restoring divide, one quotient bit a cycle
    S_DONE    // load output register
  } state_t;

endpackage

>>> rtl/core/moisture_median_percent.sv
// ----------------------------------------------------------------------------
// moisture_median_percent
// Block median filter over raw probe samples with two-point linear
// calibration to a clamped 0..100 percent value.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+----------------------------------
//  in      | sink      | in_valid / in_stall  | sample
//  out     | source    | out_valid / out_stall| percent, filtered_raw, in_range,
//          |           |                      | updated
//  cfg     | sink      | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// Flow: a request that does not close a block goes from S_IDLE to S_DONE.
//   A request that closes a block runs a rank-count search through the
//   sample memory (one read port, one entry a cycle), trying each entry as
//   candidate until one has the median rank, then sets up the mapping and,
//   unless the percent is known directly, runs a bit-serial divide.
// Reset: rst is synchronous, active high. The sample memory is not cleared;
//   every entry is written before a block is evaluated.
// Stalls: a result waits in the output register; the next request is taken
//   while it waits, and the block holds in S_DONE only if the output is
//   still occupied when the next result is ready.
// ----------------------------------------------------------------------------
module moisture_median_percent #(
  parameter int BLOCK_SAMPLES = 9
) (
  input  logic                                clk,
  input  logic                                rst,
  // sample requests
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [mmp_pkg::RAW_W-1:0]           sample,
  // results
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [mmp_pkg::PCT_W-1:0]           percent,
  output logic [mmp_pkg::RAW_W-1:0]           filtered_raw,
  output logic                                in_range,
  output logic                                updated,
  // configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mmp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mmp_pkg::RAW_W-1:0]           cfg_data
);

  // Address width of the sample memory and width of a 0..N counter
  localparam int AW = (BLOCK_SAMPLES > 1) ? $clog2(BLOCK_SAMPLES) : 1;
  localparam int CW = $clog2(BLOCK_SAMPLES + 1);
  localparam int RW = mmp_pkg::RAW_W;
  localparam int PW = mmp_pkg::PROD_W;

  localparam logic [AW-1:0] LAST_IDX   = AW'(BLOCK_SAMPLES - 1);
  localparam logic [AW-1:0] MED_RANK   = AW'(BLOCK_SAMPLES / 2);
  localparam logic [CW-1:0] SCAN_COUNT = CW'(BLOCK_SAMPLES);

  // --------------------------------------------------------------------------
  // Calibration registers
  // --------------------------------------------------------------------------
  logic [RW-1:0] dry_raw;
  logic [RW-1:0] wet_raw;
  logic [RW-1:0] valid_high;
  logic [RW-1:0] valid_low;

  mmp_pkg::state_t state;
  mmp_pkg::state_t state_next;

  assign cfg_ready = (state == mmp_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      dry_raw    <= mmp_pkg::RAW_MAX;
      wet_raw    <= mmp_pkg::RAW_MIN;
      valid_high <= mmp_pkg::RAW_MAX;
      valid_low  <= mmp_pkg::RAW_MIN;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mmp_pkg::REG_DRY_RAW:    dry_raw    <= cfg_data;
        mmp_pkg::REG_WET_RAW:    wet_raw    <= cfg_data;
        mmp_pkg::REG_VALID_HIGH: valid_high <= cfg_data;
        mmp_pkg::REG_VALID_LOW:  valid_low  <= cfg_data;
        default: ;  // unused indexes are dropped
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sample memory: one write port (request side), one registered read port
  // --------------------------------------------------------------------------
  logic [RW-1:0] sample_store [BLOCK_SAMPLES];
  logic [RW-1:0] rd_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          in_take;
  logic [AW-1:0] fill_count;

  assign in_stall = (state != mmp_pkg::S_IDLE);
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (in_take) begin
      sample_store[fill_count] <= sample;
    end
    if (rd_en) begin
      rd_data <= sample_store[rd_addr];
    end
  end

  // --------------------------------------------------------------------------
  // Control
  // --------------------------------------------------------------------------
  logic [AW-1:0]          ci;       // candidate index
  logic [CW-1:0]          jj;       // next scan read index
  logic [RW-1:0]          cand;     // candidate value
  logic                   rd_vld;   // rd_data holds a scan element
  logic [AW-1:0]          rd_tag;   // index of that element
  logic [AW-1:0]          less_cnt; // entries ranked below the candidate
  logic                   out_free;
  logic [PW-1:0]          div_rem;
  logic [RW-1:0]          div_den;
  logic [mmp_pkg::QBIT_W-1:0] div_k;
  logic [mmp_pkg::PCT_W-1:0]  div_q;
  logic                   map_direct;   // percent known without dividing

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mmp_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    rd_addr    = ci;
    unique case (state)
      mmp_pkg::S_IDLE: begin
        if (in_take) begin
          state_next = (fill_count == LAST_IDX) ? mmp_pkg::S_CAND : mmp_pkg::S_DONE;
        end
      end
      mmp_pkg::S_CAND: begin
        rd_en      = 1'b1;
        rd_addr    = ci;
        state_next = mmp_pkg::S_CWAIT;
      end
      mmp_pkg::S_CWAIT: begin
        rd_en      = 1'b1;
        rd_addr    = '0;
        state_next = mmp_pkg::S_SCAN;
      end
      mmp_pkg::S_SCAN: begin
        rd_addr = jj[AW-1:0];
        if (jj < SCAN_COUNT) begin
          rd_en = 1'b1;
        end else begin
          state_next = mmp_pkg::S_RANK;
        end
      end
      mmp_pkg::S_RANK: begin
        if (less_cnt != MED_RANK) begin
          state_next = mmp_pkg::S_CAND;
        end else if (map_direct) begin
          state_next = mmp_pkg::S_DONE;
        end else begin
          state_next = mmp_pkg::S_DIV;
        end
      end
      mmp_pkg::S_DIV: begin
        if (div_k == '0) begin
          state_next = mmp_pkg::S_DONE;
        end
      end
      mmp_pkg::S_DONE: begin
        if (out_free) begin
          state_next = mmp_pkg::S_IDLE;
        end
      end
      default: state_next = mmp_pkg::S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Rank compare: ties broken by index so every entry has a unique rank
  // --------------------------------------------------------------------------
  logic ranks_below;
  assign ranks_below = (rd_data < cand) || ((rd_data == cand) && (rd_tag < ci));

  // --------------------------------------------------------------------------
  // Mapping setup, evaluated on the candidate in S_RANK.
  // p = (m - d) * 100 / (w - d), truncated; negative quotients clamp to 0, those above 100 to 100, w = d gives 0.
  // --------------------------------------------------------------------------
  logic          md_pos, md_neg, wd_pos, wd_zero;
  logic [RW-1:0] abs_md, abs_wd;
  logic [PW-1:0] prod;
  logic [mmp_pkg::PCT_W-1:0] map_pct;

  always_comb begin
    md_pos  = cand > dry_raw;
    md_neg  = cand < dry_raw;
    wd_pos  = wet_raw > dry_raw;
    wd_zero = wet_raw == dry_raw;
    abs_md  = md_neg ? (dry_raw - cand) : (cand - dry_raw);
    abs_wd  = wd_pos ? (wet_raw - dry_raw) : (dry_raw - wet_raw);
    prod    = PW'(abs_md) * PW'(mmp_pkg::PCT_FULL);
    map_direct = 1'b1;
    map_pct    = mmp_pkg::PCT_ZERO;
    priority if (wd_zero) begin
      map_pct = mmp_pkg::PCT_ZERO;
    end else if (!md_pos && !md_neg) begin
      map_pct = mmp_pkg::PCT_ZERO;
    end else if ((wd_pos && md_neg) || (!wd_pos && md_pos)) begin
      map_pct = mmp_pkg::PCT_ZERO;          // opposite side of dry point
    end else if (abs_md >= abs_wd) begin
      map_pct = mmp_pkg::PCT_FULL;          // at or past the wet point
    end else begin
      map_direct = 1'b0;                    // quotient below 100: divide
    end
  end

  // Current divisor step: den << k
  logic [PW-1:0] div_shift;
  assign div_shift = PW'(div_den) << div_k;

  // --------------------------------------------------------------------------
  // Datapath registers
  // --------------------------------------------------------------------------
  logic [RW-1:0]              median_hold;
  logic [mmp_pkg::PCT_W-1:0]  percent_hold;
  logic                       upd_flag;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count   <= '0;
      median_hold  <= '0;
      percent_hold <= '0;
      upd_flag     <= 1'b0;
      rd_vld       <= 1'b0;
      ci           <= '0;
      jj           <= '0;
      less_cnt     <= '0;
    end else begin
      rd_vld <= 1'b0;
      unique case (state)
        mmp_pkg::S_IDLE: begin
          if (in_take) begin
            if (fill_count == LAST_IDX) begin
              fill_count <= '0;
              upd_flag   <= 1'b1;
              ci         <= '0;
            end else begin
              fill_count <= fill_count + AW'(1);
              upd_flag   <= 1'b0;
            end
          end
        end
        mmp_pkg::S_CAND: begin
          less_cnt <= '0;
        end
        mmp_pkg::S_CWAIT: begin
          cand   <= rd_data;
          rd_vld <= 1'b1;
          rd_tag <= '0;
          jj     <= CW'(1);
        end
        mmp_pkg::S_SCAN: begin
          if (rd_vld && ranks_below) begin
            less_cnt <= less_cnt + AW'(1);
          end
          if (jj < SCAN_COUNT) begin
            rd_vld <= 1'b1;
            rd_tag <= jj[AW-1:0];
            jj     <= jj + CW'(1);
          end
        end
        mmp_pkg::S_RANK: begin
          if (less_cnt != MED_RANK) begin
            ci <= ci + AW'(1);
          end else begin
            median_hold <= cand;
            if (map_direct) begin
              percent_hold <= map_pct;
            end
            div_rem <= prod;
            div_den <= abs_wd;
            div_k   <= mmp_pkg::QBIT_TOP;
            div_q   <= '0;
          end
        end
        mmp_pkg::S_DIV: begin
          if (div_rem >= div_shift) begin
            div_rem <= div_rem - div_shift;
          end
          div_k <= div_k - mmp_pkg::QBIT_W'(1);
          if (div_k == '0) begin
            percent_hold <= {div_q[mmp_pkg::PCT_W-2:0], (div_rem >= div_shift)};
          end else begin
            div_q <= {div_q[mmp_pkg::PCT_W-2:0], (div_rem >= div_shift)};
          end
        end
        mmp_pkg::S_DONE: ;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic out_load;
  assign out_load = (state == mmp_pkg::S_DONE) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_load || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      percent      <= percent_hold;
      filtered_raw <= median_hold;
      in_range     <= (median_hold >= valid_low) && (median_hold <= valid_high);
      updated      <= upd_flag;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------

  // Every accepted request goes through the sequencer before the next one.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_take |=> (state == mmp_pkg::S_CAND || state == mmp_pkg::S_DONE))
    else $error("request accepted while previous one still in flight");

  // The last candidate must be the median; ranks are unique.
  a_rank_found: assert property (@(posedge clk) disable iff (rst)
    (state == mmp_pkg::S_RANK && ci == LAST_IDX) |-> (less_cnt == MED_RANK))
    else $error("no candidate matched the median rank");

  // Scan index never runs past the block.
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == mmp_pkg::S_SCAN) |-> (jj <= SCAN_COUNT))
    else $error("scan index beyond block");

  // Restoring divide invariant: remainder below twice the current step.
  a_div_bound: assert property (@(posedge clk) disable iff (rst)
    (state == mmp_pkg::S_DIV) |-> ({1'b0, div_rem} < ({1'b0, div_shift} << 1)))
    else $error("divide remainder out of range, quotient overflow");

endmodule

>>> tb/moisture_percent_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// moisture_percent_checker
// Watches the sample, result and register channels of the moisture block,
// predicts each reading from its own copy of the block state and compares
// every result field with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module moisture_percent_checker #(
  parameter int BLOCK_SAMPLES = 9
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [mmp_pkg::RAW_W-1:0]     sample,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [mmp_pkg::PCT_W-1:0]     percent,
  input  logic [mmp_pkg::RAW_W-1:0]     filtered_raw,
  input  logic                          in_range,
  input  logic                          updated,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [mmp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mmp_pkg::RAW_W-1:0]     cfg_data,
  output int                            errors,
  output int                            pending
);
  import mmp_pkg::*;

  typedef struct packed {
    logic [PCT_W-1:0] percent;
    logic [RAW_W-1:0] filtered_raw;
    logic             in_range;
    logic             updated;
  } reading_t;

  // calibration and window copies
  logic [RAW_W-1:0] dry_cal;
  logic [RAW_W-1:0] wet_cal;
  logic [RAW_W-1:0] win_high;
  logic [RAW_W-1:0] win_low;

  // filter state
  logic [RAW_W-1:0] block_store [BLOCK_SAMPLES];
  int               fill;
  logic [RAW_W-1:0] median_held;
  logic [PCT_W-1:0] pct_held;

  reading_t expected_readings [$];

  initial errors = 0;
  initial pending = 0;

  task automatic flag_mismatch(input string msg);
    $display("ERROR %0t: %s", $time, msg);
    errors++;
  endtask

  // one sample in, one reading out; updates the held values on a full block
  function automatic reading_t predict_reading(input logic [RAW_W-1:0] s);
    reading_t         r;
    logic [RAW_W-1:0] sorted [BLOCK_SAMPLES];
    logic [RAW_W-1:0] tmp;
    int               num;
    int               den;
    int               q;
    r.updated = 1'b0;
    block_store[fill] = s;
    fill++;
    if (fill >= BLOCK_SAMPLES) begin
      sorted = block_store;
      for (int i = 0; i < BLOCK_SAMPLES - 1; i++) begin
        for (int j = 0; j < BLOCK_SAMPLES - 1 - i; j++) begin
          if (sorted[j] > sorted[j+1]) begin
            tmp = sorted[j];
            sorted[j] = sorted[j+1];
            sorted[j+1] = tmp;
          end
        end
      end
      // upper middle for even sizes
      median_held = sorted[BLOCK_SAMPLES/2];
      if (dry_cal == wet_cal) begin
        pct_held = PCT_ZERO;
      end else begin
        num = (int'(median_held) - int'(dry_cal)) * int'(PCT_FULL);
        den = int'(wet_cal) - int'(dry_cal);
        q = num / den;  // truncates toward zero
        if (q < 0) q = 0;
        if (q > int'(PCT_FULL)) q = int'(PCT_FULL);
        pct_held = PCT_W'(q);
      end
      fill = 0;
      r.updated = 1'b1;
    end
    r.percent = pct_held;
    r.filtered_raw = median_held;
    r.in_range = (median_held >= win_low) && (median_held <= win_high);
    return r;
  endfunction

  always @(posedge clk) begin
    reading_t want;
    if (rst) begin
      dry_cal = RAW_MAX;
      wet_cal = RAW_MIN;
      win_high = RAW_MAX;
      win_low = RAW_MIN;
      fill = 0;
      median_held = '0;
      pct_held = PCT_ZERO;
      foreach (block_store[i]) block_store[i] = '0;
      expected_readings.delete();
    end else begin
      // results first: a result can never come from a request taken this edge
      if (out_valid && !out_stall) begin
        if (expected_readings.size() == 0) begin
          flag_mismatch($sformatf("result with no request waiting (percent %0d raw %0d)",
                                  percent, filtered_raw));
        end else begin
          want = expected_readings.pop_front();
          if (percent !== want.percent)
            flag_mismatch($sformatf("percent got %0d expected %0d",
                                    percent, want.percent));
          if (filtered_raw !== want.filtered_raw)
            flag_mismatch($sformatf("filtered_raw got %0d expected %0d",
                                    filtered_raw, want.filtered_raw));
          if (in_range !== want.in_range)
            flag_mismatch($sformatf("in_range got %0b expected %0b",
                                    in_range, want.in_range));
          if (updated !== want.updated)
            flag_mismatch($sformatf("updated got %0b expected %0b",
                                    updated, want.updated));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_DRY_RAW:    dry_cal = cfg_data;
          REG_WET_RAW:    wet_cal = cfg_data;
          REG_VALID_HIGH: win_high = cfg_data;
          REG_VALID_LOW:  win_low = cfg_data;
          default: ;  // spare indexes are ignored
        endcase
      end
      if (in_valid && !in_stall)
        expected_readings.push_back(predict_reading(sample));
    end
    pending = expected_readings.size();
  end

endmodule

>>> tb/tb_moisture_median_percent.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_moisture_median_percent
// Drives probe samples and calibration writes into the moisture median block
// under random sender and receiver stalls; the checker does the scoring.
// ----------------------------------------------------------------------------
module tb_moisture_median_percent;
  import mmp_pkg::*;

  localparam int BLOCK_SAMPLES = 9;
  localparam int LIMIT_CYCLES  = 2_000_000;  // far above the slowest legal run
  localparam int DRAIN_CYCLES  = 150;        // covers the slowest block close
  localparam int HOLD_CYCLES   = 400;        // long receiver hold-off
  localparam int SEGMENTS      = 6;          // calibration changes per phase
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = REG_VALID_LOW + 1'b1;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [RAW_W-1:0]     sample = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [PCT_W-1:0]     percent;
  logic [RAW_W-1:0]     filtered_raw;
  logic                 in_range;
  logic                 updated;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_DRY_RAW;
  logic [RAW_W-1:0]     cfg_data = '0;

  int  errors;
  int  pending;
  int  cycle_count = 0;

  // stall shaping
  int   sender_idle_pct = 0;
  int   recv_idle_pct = 0;
  logic hold_start = 1'b0;
  int   hold_left = 0;

  // raw span between the calibration points, steers the random samples
  int band_lo = 0;
  int band_hi = 4095;

  moisture_median_percent #(.BLOCK_SAMPLES(BLOCK_SAMPLES)) DUT (.*);

  moisture_percent_checker #(.BLOCK_SAMPLES(BLOCK_SAMPLES)) scoreboard (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result side: random stalls, or a long hold-off counted here so the
  // output register fills and the block pushes back on its input.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_start) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // one sample request, with random idle cycles ahead of it
  task automatic send_sample(input logic [RAW_W-1:0] v);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    sample <= v;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RAW_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // drop valid, let every reading come back, then let the block settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // all four registers plus one spare index that must be ignored
  task automatic write_calibration(input logic [RAW_W-1:0] dry, input logic [RAW_W-1:0] wet,
                                   input logic [RAW_W-1:0] vhi, input logic [RAW_W-1:0] vlo);
    wait_idle();
    write_reg(REG_DRY_RAW, dry);
    write_reg(REG_WET_RAW, wet);
    write_reg(CFG_IDX_W'($urandom_range(int'(REG_SPARE), (1 << CFG_IDX_W) - 1)),
              RAW_W'($urandom));
    write_reg(REG_VALID_HIGH, vhi);
    write_reg(REG_VALID_LOW, vlo);
    cfg_valid <= 1'b0;
    band_lo = (dry < wet) ? dry : wet;
    band_hi = (dry < wet) ? wet : dry;
  endtask

  // half of the values near or on the calibration span so the percent moves
  function automatic logic [RAW_W-1:0] draw_sample();
    int pick;
    int lo;
    int hi;
    pick = $urandom_range(99);
    lo = (band_lo > 100) ? band_lo - 100 : 0;
    hi = (band_hi < 3995) ? band_hi + 100 : 4095;
    if (pick < 40) return RAW_W'($urandom);
    if (pick < 80) return RAW_W'($urandom_range(hi, lo));
    if (pick < 90) return $urandom_range(1) ? RAW_MAX : RAW_MIN;
    return RAW_W'($urandom_range(1) ? band_lo : band_hi);
  endfunction

  initial begin : stimulus
    logic [RAW_W-1:0] dry;
    logic [RAW_W-1:0] wet;
    logic [RAW_W-1:0] vhi;
    logic [RAW_W-1:0] vlo;
    int               count;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    sender_idle_pct = 17;
    recv_idle_pct = 66;

    // Directed. Reset calibration (dry at full scale, wet at zero): the
    // first eight readings report the zero held values. Block median 2048.
    send_sample(RAW_MIN);
    send_sample(RAW_MAX);
    send_sample(12'hAAA);
    send_sample(12'h555);
    send_sample(RAW_MAX);
    send_sample(RAW_MIN);
    send_sample(RAW_MAX);
    send_sample(RAW_MIN);
    send_sample(12'd2048);

    // equal calibration points and an inverted window
    write_calibration(12'd1000, 12'd1000, 12'd100, 12'd3000);
    repeat (BLOCK_SAMPLES) send_sample(RAW_MAX);

    // widest ascending span, full window; partial block runs on into random
    write_calibration(RAW_MIN, RAW_MAX, RAW_MAX, RAW_MIN);
    send_sample(RAW_MAX);
    send_sample(RAW_MIN);
    send_sample(12'd2047);
    send_sample(12'd4094);
    send_sample(12'd1);
    send_sample(12'd2048);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 17; recv_idle_pct = 66; end
        1: begin sender_idle_pct = 66; recv_idle_pct = 17; end
        default: begin sender_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int seg = 0; seg < SEGMENTS; seg++) begin
        case (seg)
          0: begin dry = 12'd3000; wet = 12'd1200; vhi = 12'd3500; vlo = 12'd500; end
          1: begin dry = RAW_MAX; wet = RAW_MIN; vhi = RAW_MIN; vlo = RAW_MAX; end
          2: begin dry = RAW_MIN; wet = RAW_MAX; vhi = RAW_MAX; vlo = RAW_MIN; end
          3: begin
            dry = RAW_W'($urandom);
            wet = dry;
            vlo = RAW_W'($urandom);
            vhi = RAW_W'($urandom_range(4095, int'(vlo)));
          end
          default: begin
            dry = RAW_W'($urandom);
            wet = RAW_W'($urandom);
            vlo = RAW_W'($urandom);
            // mostly a sane window, sometimes inverted
            vhi = ($urandom_range(3) != 0) ? RAW_W'($urandom_range(4095, int'(vlo)))
                                           : RAW_W'($urandom);
          end
        endcase
        write_calibration(dry, wet, vhi, vlo);

        // back-pressure burst: receiver holds off while samples keep coming
        if (phase == 2 && seg == 0) begin
          hold_start <= 1'b1;
          @(posedge clk);
          hold_start <= 1'b0;
        end

        // random segment lengths, often not a multiple of the block size, so
        // blocks straddle calibration changes
        count = $urandom_range(160, 60);
        repeat (count) send_sample(draw_sample());
      end
    end

    wait_idle();
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/mmp_pkg.sv
rtl/core/moisture_median_percent.sv
tb/moisture_percent_checker.sv
tb/tb_moisture_median_percent.sv
